@@ rtl/pis_pkg.sv @@
// Package for the particle integration step block: payload structs, widths,
// attribute codes, memory word layout and Q16.16 helper functions.
// Depends on nothing.
package pis_pkg;

    localparam int PARTICLES_DEF = 256;
    localparam int SLOT_W = 8;
    localparam int DATA_W = 32;
    localparam int DT_W = 31;
    localparam int ATTR_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_FIELDS = 22;
    localparam int ROW_W = NUM_FIELDS * DATA_W;

    // Field positions inside one memory row.
    localparam int F_LIFE = 0;
    localparam int F_AGE = 1;
    localparam int F_POS = 2;
    localparam int F_VEL = 5;
    localparam int F_COL = 8;
    localparam int F_CRT = 11;
    localparam int F_ALPHA = 14;
    localparam int F_ARATE = 15;
    localparam int F_SIZE = 16;
    localparam int F_SRATE = 17;

    // Load attribute codes.
    localparam logic [ATTR_W-1:0] ATTR_LIFE = 5'd0;
    localparam logic [ATTR_W-1:0] ATTR_LAST = 5'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_Z = 3'd6;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [SLOT_W-1:0]        slot;
        logic [ATTR_W-1:0]        attr_select;
        logic signed [DATA_W-1:0] value;
        logic [DT_W-1:0]          dt;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]        out_slot;
        logic                     out_alive;
        logic signed [DATA_W-1:0] out_pos_x;
        logic signed [DATA_W-1:0] out_pos_y;
        logic signed [DATA_W-1:0] out_pos_z;
        logic signed [DATA_W-1:0] out_red;
        logic signed [DATA_W-1:0] out_green;
        logic signed [DATA_W-1:0] out_blue;
        logic signed [DATA_W-1:0] out_alpha;
        logic signed [DATA_W-1:0] out_size;
    } out_item_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (x < -34'sh0_8000_0000) r = 32'sh8000_0000;
        else r = x[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        return sat34(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        return sat34(34'(a) - 34'(b));
    endfunction

    // Product of a signed value and dt, arithmetic shift right by 16, saturated.
    function automatic logic signed [DATA_W-1:0] mul_dt(input logic signed [DATA_W-1:0] a,
                                                        input logic [DT_W-1:0] dt);
        logic signed [63:0] p;
        logic signed [47:0] q;
        logic signed [DATA_W-1:0] r;
        p = 64'(a) * $signed({33'd0, dt});
        q = p[63:16];
        if (q > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (q < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = q[DATA_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/pis_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/pis_alu.sv @@
// Update datapath: ages, integrates and ramps one particle row read from memory.
// Depends on pis_pkg. Stage one forms the dt products and the new age, stage two the rest.
module pis_alu (
    input  logic                          clk,
    input  logic [pis_pkg::ROW_W-1:0]     row_in,
    input  logic [pis_pkg::DT_W-1:0]      dt,
    input  logic signed [pis_pkg::DATA_W-1:0] grav [3],
    input  logic signed [pis_pkg::DATA_W-1:0] attr [3],
    input  logic                          attract_en,
    output logic [pis_pkg::ROW_W-1:0]     row_out,
    output logic                          kill
);
    import pis_pkg::*;

    typedef logic signed [DATA_W-1:0] w_t;

    w_t f [NUM_FIELDS];
    w_t pv_reg [3];
    w_t gv_reg [3];
    w_t cv_reg [3];
    w_t av_reg, sv_reg, age_reg;
    w_t new_pos [3];
    w_t new_vel [3];
    w_t m5 [3];
    w_t r [NUM_FIELDS];
    logic [ROW_W-1:0] row_reg;
    logic [DT_W-1:0] dt_reg;
    logic signed [34:0] d5;

    always_comb
    begin
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            f[i] = row_in[i*DATA_W +: DATA_W];
        end
    end

    // Stage one: the rate, velocity and gravity products by dt, and the new age.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pv_reg[k] <= mul_dt(f[F_VEL+k], dt);
            gv_reg[k] <= mul_dt(grav[k], dt);
            cv_reg[k] <= mul_dt(f[F_CRT+k], dt);
        end
        av_reg <= mul_dt(f[F_ARATE], dt);
        sv_reg <= mul_dt(f[F_SRATE], dt);
        age_reg <= sat34(34'(f[F_AGE]) + $signed({3'd0, dt}));
        row_reg <= row_in;
        dt_reg <= dt;
    end

    // Stage two: sums, attraction and the kill test.
    always_comb
    begin
        d5 = '0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            r[i] = row_reg[i*DATA_W +: DATA_W];
        end
        for (int k = 0; k < 3; k++)
        begin
            new_pos[k] = add_sat(r[F_POS+k], pv_reg[k]);
            new_vel[k] = add_sat(r[F_VEL+k], gv_reg[k]);
            // Five times the distance needs 35 bits before it is saturated.
            d5 = 35'(sub_sat(attr[k], new_pos[k])) * 35'sd5;
            if (d5 > 35'sh0_7FFF_FFFF) m5[k] = 32'sh7FFF_FFFF;
            else if (d5 < -35'sh0_8000_0000) m5[k] = 32'sh8000_0000;
            else m5[k] = d5[DATA_W-1:0];
            if (attract_en)
            begin
                new_vel[k] = add_sat(new_vel[k], mul_dt(m5[k], dt_reg));
            end
            r[F_POS+k] = new_pos[k];
            r[F_VEL+k] = new_vel[k];
            r[F_COL+k] = add_sat(r[F_COL+k], cv_reg[k]);
        end
        r[F_ALPHA] = add_sat(r[F_ALPHA], av_reg);
        r[F_SIZE] = add_sat(r[F_SIZE], sv_reg);
        kill = age_reg >= w_t'(row_reg[F_LIFE*DATA_W +: DATA_W]);
        if (kill)
        begin
            r = '{default: '0};
            r[F_LIFE] = row_reg[F_LIFE*DATA_W +: DATA_W];
            for (int k = 0; k < 3; k++)
            begin
                r[F_POS+k] = row_reg[(F_POS+k)*DATA_W +: DATA_W];
                r[F_VEL+k] = row_reg[(F_VEL+k)*DATA_W +: DATA_W];
                r[F_COL+k] = row_reg[(F_COL+k)*DATA_W +: DATA_W];
                r[F_CRT+k] = row_reg[(F_CRT+k)*DATA_W +: DATA_W];
            end
            r[F_ALPHA] = row_reg[F_ALPHA*DATA_W +: DATA_W];
            r[F_ARATE] = row_reg[F_ARATE*DATA_W +: DATA_W];
            r[F_SIZE] = row_reg[F_SIZE*DATA_W +: DATA_W];
            r[F_SRATE] = row_reg[F_SRATE*DATA_W +: DATA_W];
        end
        r[F_AGE] = age_reg;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            row_out[i*DATA_W +: DATA_W] = r[i];
        end
    end
endmodule

@@ rtl/particle_integration_step_core.sv @@
// Particle integration step core: an update transaction goes from acceptance through
// the read, calc and write states (memory read, dt products, then sums with write-back); a
// load goes through read and calc. One transaction is in flight at a time, set by the
// read-modify-write of the particle row memory; none is accepted while a result waits.
// Reset clears the configuration and all alive flags at once;
// the particle memory itself is not cleared.
module particle_integration_step_core #(
    parameter int PARTICLES = pis_pkg::PARTICLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pis_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pis_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pis_pkg::DATA_W-1:0]         cfg_wdata
);
    import pis_pkg::*;

    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] { S_IDLE, S_READ, S_CALC, S_WRITE, S_OUT } state_t;

    state_t state_reg;
    in_item_t item_reg;
    logic [PARTICLES-1:0] alive_reg;
    logic signed [DATA_W-1:0] grav_reg [3];
    logic signed [DATA_W-1:0] attr_reg [3];
    logic attract_en_reg;
    logic out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;

    logic [ROW_W-1:0] rd_row, alu_row, wr_row;
    logic kill;
    logic we;
    logic inrange;
    logic live;
    logic [AW-1:0] addr;

    assign addr = AW'(item_reg.slot);
    assign inrange = {24'd0, item_reg.slot} < 32'(PARTICLES);
    assign live = inrange && alive_reg[addr];
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    pis_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(addr), .wdata(wr_row), .raddr(addr), .rdata(rd_row)
    );

    pis_alu u_alu (
        .clk(clk), .row_in(rd_row), .dt(item_reg.dt), .grav(grav_reg), .attr(attr_reg),
        .attract_en(attract_en_reg), .row_out(alu_row), .kill(kill)
    );

    // Memory write data: a load patches one field (lifetime also zeroes the age), an update writes back.
    always_comb
    begin
        wr_row = alu_row;
        we = 1'b0;
        if (item_reg.func == FUNC_LOAD)
        begin
            wr_row = rd_row;
            if (item_reg.attr_select == ATTR_LIFE)
            begin
                wr_row[F_LIFE*DATA_W +: DATA_W] = item_reg.value;
                wr_row[F_AGE*DATA_W +: DATA_W] = '0;
            end
            else
            begin
                wr_row[(32'(item_reg.attr_select) + 1)*DATA_W +: DATA_W] = item_reg.value;
            end
            we = (state_reg == S_CALC) && inrange && (item_reg.attr_select <= ATTR_LAST);
        end
        else
        begin
            we = (state_reg == S_WRITE) && live;
        end
    end

    // Result of an update: a live, surviving slot reports its new row, otherwise zeros apart from the slot number.
    always_comb
    begin
        out_next = '0;
        out_next.out_slot = item_reg.slot;
        if (live && !kill)
        begin
            out_next.out_alive = 1'b1;
            out_next.out_pos_x = alu_row[(F_POS+0)*DATA_W +: DATA_W];
            out_next.out_pos_y = alu_row[(F_POS+1)*DATA_W +: DATA_W];
            out_next.out_pos_z = alu_row[(F_POS+2)*DATA_W +: DATA_W];
            out_next.out_red = alu_row[(F_COL+0)*DATA_W +: DATA_W];
            out_next.out_green = alu_row[(F_COL+1)*DATA_W +: DATA_W];
            out_next.out_blue = alu_row[(F_COL+2)*DATA_W +: DATA_W];
            out_next.out_alpha = alu_row[F_ALPHA*DATA_W +: DATA_W];
            out_next.out_size = alu_row[F_SIZE*DATA_W +: DATA_W];
        end
    end

    // Sequencer, alive flags, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            alive_reg <= '0;
            out_valid_reg <= 1'b0;
            attract_en_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                grav_reg[k] <= '0;
                attr_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRAV_X: grav_reg[0] <= cfg_wdata;
                    CFG_GRAV_Y: grav_reg[1] <= cfg_wdata;
                    CFG_GRAV_Z: grav_reg[2] <= cfg_wdata;
                    CFG_ATTR_EN: attract_en_reg <= cfg_wdata[0];
                    CFG_ATT_X: attr_reg[0] <= cfg_wdata;
                    CFG_ATT_Y: attr_reg[1] <= cfg_wdata;
                    CFG_ATT_Z: attr_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_CALC;
                S_CALC:
                begin
                    if (item_reg.func == FUNC_LOAD)
                    begin
                        if (inrange && item_reg.attr_select == ATTR_LIFE)
                        begin
                            alive_reg[addr] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    out_reg <= out_next;
                    if (live && kill)
                    begin
                        alive_reg[addr] <= 1'b0;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A result is never raised while a transaction is still being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !$rose(out_valid_reg))
        else $error("result raised during read");
    // Input is never accepted while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input accepted while result pending");
    // Each update goes from its read through the calc state to write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && item_reg.func == FUNC_UPDATE) |=> ##1 (state_reg == S_WRITE))
        else $error("update sequencing broken");
`endif
endmodule

@@ verif/tb.sv @@
// Testbench for particle_integration_step_core: directed table, then random
// load and update traffic checked against an in-bench Q16.16 particle predictor.
// Depends on pis_pkg and the core RTL.
module tb;
    import pis_pkg::*;

    // Load attribute codes beyond the lifetime code from the package.
    localparam logic [ATTR_W-1:0] ATTR_POS_X = 5'd1;
    localparam logic [ATTR_W-1:0] ATTR_VEL_X = 5'd4;
    localparam logic [ATTR_W-1:0] ATTR_COL_R = 5'd7;
    localparam logic [ATTR_W-1:0] ATTR_CRT_R = 5'd10;
    localparam logic [ATTR_W-1:0] ATTR_ALPHA = 5'd13;
    localparam logic [ATTR_W-1:0] ATTR_ARATE = 5'd14;
    localparam logic [ATTR_W-1:0] ATTR_SIZE = 5'd15;
    localparam logic [ATTR_W-1:0] ATTR_SRATE = 5'd16;
    localparam logic [ATTR_W-1:0] ATTR_BAD_LO = 5'd17;
    localparam logic [ATTR_W-1:0] ATTR_BAD_HI = 5'd31;
    localparam logic signed [DATA_W-1:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] QMIN = 32'sh8000_0000;
    localparam logic [DT_W-1:0] DT_MAX = 31'h7FFF_FFFF;
    localparam logic [16:0] ALL_LOADED = '1;
    localparam int SETTLE = 12;
    localparam int RANDOM_PER_PHASE = 340;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    particle_integration_step_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Predictor copy of the configuration and the particle table.
    logic signed [DATA_W-1:0] grav_m [3];
    logic signed [DATA_W-1:0] attractor_m [3];
    logic attract_m;
    logic alive_m [256];
    logic [16:0] loaded_m [256];
    logic signed [DATA_W-1:0] age_m [256];
    logic signed [DATA_W-1:0] life_m [256];
    logic signed [DATA_W-1:0] pos_m [256][3];
    logic signed [DATA_W-1:0] vel_m [256][3];
    logic signed [DATA_W-1:0] col_m [256][3];
    logic signed [DATA_W-1:0] crt_m [256][3];
    logic signed [DATA_W-1:0] alpha_m [256];
    logic signed [DATA_W-1:0] arate_m [256];
    logic signed [DATA_W-1:0] size_m [256];
    logic signed [DATA_W-1:0] srate_m [256];

    out_item_t expected_results [$];
    int mismatches = 0;
    bit fast_phase = 1'b0;

    function automatic logic signed [DATA_W-1:0] clamp32(longint x);
        if (x > 64'sd2147483647) return QMAX;
        if (x < -64'sd2147483648) return QMIN;
        return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] qadd(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
        return clamp32(longint'(a) + longint'(b));
    endfunction

    // Product with dt, floored back to Q16.16 by the arithmetic shift.
    function automatic logic signed [DATA_W-1:0] qscale(logic signed [DATA_W-1:0] a,
                                                        logic [DT_W-1:0] dt);
        longint p;
        p = longint'(a) * longint'(dt);
        return clamp32(p >>> 16);
    endfunction

    // Applies one accepted transaction; returns 1 when it yields a result.
    function automatic bit integrate_slot(in_item_t it, output out_item_t r);
        int s;
        int k;
        logic signed [DATA_W-1:0] d;
        s = it.slot;
        r = '0;
        if (it.func == FUNC_LOAD)
        begin
            if (it.attr_select > ATTR_LAST) return 1'b0;
            loaded_m[s][it.attr_select] = 1'b1;
            if (it.attr_select == ATTR_LIFE)
            begin
                life_m[s] = it.value;
                age_m[s] = '0;
                alive_m[s] = 1'b1;
            end
            else if (it.attr_select < ATTR_VEL_X) pos_m[s][it.attr_select - ATTR_POS_X] = it.value;
            else if (it.attr_select < ATTR_COL_R) vel_m[s][it.attr_select - ATTR_VEL_X] = it.value;
            else if (it.attr_select < ATTR_CRT_R) col_m[s][it.attr_select - ATTR_COL_R] = it.value;
            else if (it.attr_select < ATTR_ALPHA) crt_m[s][it.attr_select - ATTR_CRT_R] = it.value;
            else if (it.attr_select == ATTR_ALPHA) alpha_m[s] = it.value;
            else if (it.attr_select == ATTR_ARATE) arate_m[s] = it.value;
            else if (it.attr_select == ATTR_SIZE) size_m[s] = it.value;
            else srate_m[s] = it.value;
            return 1'b0;
        end
        r.out_slot = it.slot;
        if (!alive_m[s]) return 1'b1;
        age_m[s] = clamp32(longint'(age_m[s]) + longint'(it.dt));
        if (age_m[s] >= life_m[s])
        begin
            alive_m[s] = 1'b0;
            return 1'b1;
        end
        for (k = 0; k < 3; k++)
        begin
            pos_m[s][k] = qadd(pos_m[s][k], qscale(vel_m[s][k], it.dt));
            vel_m[s][k] = qadd(vel_m[s][k], qscale(grav_m[k], it.dt));
            if (attract_m)
            begin
                d = clamp32(longint'(attractor_m[k]) - longint'(pos_m[s][k]));
                vel_m[s][k] = qadd(vel_m[s][k], qscale(clamp32(longint'(d) * 5), it.dt));
            end
            col_m[s][k] = qadd(col_m[s][k], qscale(crt_m[s][k], it.dt));
        end
        alpha_m[s] = qadd(alpha_m[s], qscale(arate_m[s], it.dt));
        size_m[s] = qadd(size_m[s], qscale(srate_m[s], it.dt));
        r.out_alive = 1'b1;
        r.out_pos_x = pos_m[s][0];
        r.out_pos_y = pos_m[s][1];
        r.out_pos_z = pos_m[s][2];
        r.out_red = col_m[s][0];
        r.out_green = col_m[s][1];
        r.out_blue = col_m[s][2];
        r.out_alpha = alpha_m[s];
        r.out_size = size_m[s];
        return 1'b1;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (fast_phase || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return QMAX;
            1: return QMIN;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0: return DT_MAX;
            1: return DT_W'($urandom);
            2: return '0;
            default: return DT_W'($urandom_range(1, 32'h0001_8000));
        endcase
    endfunction

    // Result side: random back-pressure and the compare against the oldest expectation.
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            stall_left <= idle_cycles();
            out_ready <= 1'b1;
        end
    end

    function automatic logic [DATA_W-1:0] field_of(out_item_t r, int i);
        case (i)
            0: return DATA_W'(r.out_slot);
            1: return DATA_W'(r.out_alive);
            2: return r.out_pos_x;
            3: return r.out_pos_y;
            4: return r.out_pos_z;
            5: return r.out_red;
            6: return r.out_green;
            7: return r.out_blue;
            8: return r.out_alpha;
            default: return r.out_size;
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_item_t want;
        bit bad;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction for slot %0d", out_data.out_slot);
            end
            else
            begin
                want = expected_results.pop_front();
                bad = 1'b0;
                for (int i = 0; i < 10; i++)
                    if (field_of(want, i) !== field_of(out_data, i))
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("slot %0d field %0d: expected %h, got %h",
                                     want.out_slot, i, field_of(want, i), field_of(out_data, i));
                    end
                if (bad) mismatches++;
            end
        end
    end

    // Drives one transaction, optionally with a typed-in expectation.
    task automatic send(in_item_t it, bit typed = 1'b0, out_item_t typed_result = '0);
        int gap;
        out_item_t r;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        if (integrate_slot(it, r)) expected_results.push_back(typed ? typed_result : r);
    endtask

    task automatic load(int s, logic [ATTR_W-1:0] a, logic signed [DATA_W-1:0] v);
        in_item_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.slot = SLOT_W'(s);
        it.attr_select = a;
        it.value = v;
        it.dt = DT_W'($urandom);
        send(it);
    endtask

    task automatic update(int s, logic [DT_W-1:0] dt);
        in_item_t it;
        it = '0;
        it.func = FUNC_UPDATE;
        it.slot = SLOT_W'(s);
        it.value = $urandom;
        it.dt = dt;
        send(it);
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(logic signed [DATA_W-1:0] g [3], logic en,
                             logic signed [DATA_W-1:0] p [3]);
        logic [DATA_W-1:0] vals [7];
        vals = '{g[0], g[1], g[2], {31'd0, en}, p[0], p[1], p[2]};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        grav_m = g;
        attract_m = en;
        attractor_m = p;
    endtask

    // Directed table row: item plus an optional expectation read off by hand.
    typedef struct {
        in_item_t item;
        bit typed;
        out_item_t result;
    } dir_row_t;

    function automatic dir_row_t row(logic f, int s, logic [ATTR_W-1:0] a,
                                     logic signed [DATA_W-1:0] v, logic [DT_W-1:0] dt,
                                     bit typed = 1'b0);
        dir_row_t d;
        d.item = '{func: f, slot: SLOT_W'(s), attr_select: a, value: v, dt: dt};
        d.typed = typed;
        d.result = '0;
        d.result.out_slot = SLOT_W'(s);
        return d;
    endfunction

    initial
    begin
        dir_row_t table_rows [$];
        logic signed [DATA_W-1:0] g [3];
        logic signed [DATA_W-1:0] p [3];
        int s;
        int op;

        for (int i = 0; i < 256; i++)
        begin
            alive_m[i] = 1'b0;
            loaded_m[i] = '0;
        end
        grav_m = '{0, 0, 0};
        attractor_m = '{0, 0, 0};
        attract_m = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Dead slots right after reset, full attribute set with extremes,
        // extreme and zero time steps, an unknown attribute, a zero lifetime kill.
        table_rows.push_back(row(FUNC_UPDATE, 5, ATTR_LIFE, 0, 31'h0001_0000, 1'b1));
        table_rows.push_back(row(FUNC_UPDATE, 255, ATTR_LIFE, QMAX, DT_MAX, 1'b1));
        for (int a = ATTR_POS_X; a <= ATTR_LAST; a++)
            table_rows.push_back(row(FUNC_LOAD, 0, ATTR_W'(a), (a % 2) ? QMAX : QMIN, '0));
        table_rows.push_back(row(FUNC_LOAD, 0, ATTR_LIFE, QMAX, '0));
        table_rows.push_back(row(FUNC_UPDATE, 0, ATTR_LIFE, 0, DT_MAX));
        table_rows.push_back(row(FUNC_UPDATE, 0, ATTR_LIFE, 0, '0));
        table_rows.push_back(row(FUNC_LOAD, 0, ATTR_BAD_HI, QMIN, DT_MAX));
        table_rows.push_back(row(FUNC_LOAD, 0, ATTR_LIFE, 0, '0));
        table_rows.push_back(row(FUNC_UPDATE, 0, ATTR_BAD_LO, 0, '0, 1'b1));
        table_rows.push_back(row(FUNC_UPDATE, 0, ATTR_LIFE, 0, 31'h0000_0100, 1'b1));
        foreach (table_rows[i]) send(table_rows[i].item, table_rows[i].typed, table_rows[i].result);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    g = '{0, 0, 0};
                    p = '{0, 0, 0};
                    configure(g, 1'b0, p);
                end
                1:
                begin
                    g = '{QMAX, QMIN, 0};
                    p = '{QMIN, QMAX, 0};
                    configure(g, 1'b1, p);
                end
                2:
                begin
                    g = '{$urandom, $urandom, $urandom};
                    p = '{$urandom, $urandom, $urandom};
                    configure(g, 1'b1, p);
                end
                3:
                begin
                    g = '{32'sh0000_8000, -32'sh0009_CCCC, 32'sh0000_0100};
                    p = '{32'sh0010_0000, 0, -32'sh0010_0000};
                    configure(g, 1'b1, p);
                end
                default:
                begin
                    g = '{QMIN, QMAX, QMIN};
                    p = '{QMAX, QMIN, QMAX};
                    configure(g, 1'b0, p);
                end
            endcase
            fast_phase = (ph == 3);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
                op = $urandom_range(0, 99);
                if (op < 50) update(s, pick_dt());
                else if (op < 85)
                    load(s, ATTR_W'($urandom_range(ATTR_POS_X, ATTR_LAST)), pick_value());
                else if (op < 90)
                    load(s, ATTR_W'($urandom_range(ATTR_BAD_LO, ATTR_BAD_HI)), pick_value());
                else
                begin
                    // A lifetime load revives the slot, so a slot not yet fully loaded gets every attribute first.
                    if (loaded_m[s] != ALL_LOADED)
                        for (int a = ATTR_POS_X; a <= ATTR_LAST; a++)
                            load(s, ATTR_W'(a), pick_value());
                    load(s, ATTR_LIFE, ($urandom_range(0, 9) == 0) ? pick_value()
                                       : $signed($urandom_range(0, 32'h0008_0000)));
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/pis_pkg.sv
rtl/pis_ram.sv
rtl/pis_alu.sv
rtl/particle_integration_step_core.sv
verif/tb.sv
